>>> hw/rtl/fwma_pkg.sv
// shared constants and types for the forward window moving average unit
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package fwma_pkg;

    localparam int SAMPLE_W = 48;
    localparam int WINDOW_LENGTH_DEF = 5;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

`default_nettype wire

>>> hw/rtl/fwma_hist_mem.sv
// row history memory, one write port and one registered read port
// depends on nothing outside this file
`timescale 1ns / 1ps
`default_nettype none

module fwma_hist_mem #(
    parameter int DEPTH = 5,
    parameter int DATA_W = 96,
    parameter int ADDR_W = 3
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> hw/rtl/fwma_divider.sv
// two-lane iterative signed divider, one quotient bit per cycle, truncates toward zero
// depends on fwma_pkg for the status struct
`timescale 1ns / 1ps
`default_nettype none

module fwma_divider #(
    parameter int SUM_W = 51,
    parameter int CNT_W = 3
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic signed [SUM_W-1:0] dividend_close,
    input  wire logic signed [SUM_W-1:0] dividend_open,
    input  wire logic        [CNT_W-1:0] divisor,
    output logic signed      [SUM_W-1:0] quotient_close,
    output logic signed      [SUM_W-1:0] quotient_open,
    output fwma_pkg::div_status_t        status
);

    import fwma_pkg::*;

    localparam int ITER_W = $clog2(SUM_W + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [ITER_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0]  dsr_reg, dsr_next;
    logic [SUM_W-1:0]  dvd_reg [2];
    logic [SUM_W-1:0]  dvd_next [2];
    logic [CNT_W-1:0]  rem_reg [2];
    logic [CNT_W-1:0]  rem_next [2];
    logic              neg_reg [2];
    logic              neg_next [2];
    logic [SUM_W-1:0]  src [2];
    logic [CNT_W:0]    shifted [2];
    logic              qbit [2];

    assign src[0] = dividend_close;
    assign src[1] = dividend_open;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = done_reg;
        cnt_next  = cnt_reg;
        dsr_next  = dsr_reg;
        for (int i = 0; i < 2; i++)
        begin
            dvd_next[i] = dvd_reg[i];
            rem_next[i] = rem_reg[i];
            neg_next[i] = neg_reg[i];
            shifted[i]  = {rem_reg[i], dvd_reg[i][SUM_W-1]};
            qbit[i]     = (shifted[i] >= {1'b0, dsr_reg});
        end
        if (start)
        begin
            busy_next = 1'b1;
            done_next = 1'b0;
            cnt_next  = ITER_W'(SUM_W);
            dsr_next  = divisor;
            for (int i = 0; i < 2; i++)
            begin
                neg_next[i] = src[i][SUM_W-1];
                dvd_next[i] = src[i][SUM_W-1] ? (~src[i] + 1'b1) : src[i];
                rem_next[i] = '0;
            end
        end
        else if (busy_reg)
        begin
            for (int i = 0; i < 2; i++)
            begin
                rem_next[i] = qbit[i] ? CNT_W'(shifted[i] - {1'b0, dsr_reg})
                                      : shifted[i][CNT_W-1:0];
                dvd_next[i] = {dvd_reg[i][SUM_W-2:0], qbit[i]};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == ITER_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dsr_reg <= dsr_next;
        for (int i = 0; i < 2; i++)
        begin
            dvd_reg[i] <= dvd_next[i];
            rem_reg[i] <= rem_next[i];
            neg_reg[i] <= neg_next[i];
        end
    end

    assign quotient_close = neg_reg[0] ? signed'(~dvd_reg[0] + 1'b1) : signed'(dvd_reg[0]);
    assign quotient_open  = neg_reg[1] ? signed'(~dvd_reg[1] + 1'b1) : signed'(dvd_reg[1]);
    assign status.busy    = busy_reg;
    assign status.done    = done_reg;

endmodule

`default_nettype wire

>>> hw/rtl/forward_window_moving_average_unit.sv
// top level: forward window moving average over close and open samples
// depends on fwma_pkg, fwma_hist_mem and fwma_divider
//
// usage
//   input channel in_valid/in_ready carries one row per transaction: close and open
//   samples (signed Q31.16) with present flags, and series_end on the final row
//   output channel out_valid/out_ready carries one window mean per transaction
//   a row that fills the window yields the mean of the oldest row's window; a row
//   with series_end also flushes every remaining window, final_result on the last
// divider and input flow
//   each result comes from the shared
//   iterative divider that produces one quotient bit per cycle on both lanes
//   a row yields 0 to WINDOW_LENGTH results; in_ready is high only when the block
//   holds no pending work, so the next row is not accepted until every result of
//   the row before has been loaded into the output register
// reset
//   history is empty, sums are zero and no result is pending
// stall
//   a result waits in the output register; while it is not taken the next result
//   holds in the emit step, which keeps in_ready low
`timescale 1ns / 1ps
`default_nettype none

module forward_window_moving_average_unit #(
    parameter int WINDOW_LENGTH = fwma_pkg::WINDOW_LENGTH_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic signed [fwma_pkg::SAMPLE_W-1:0] close_sample,
    input  wire logic                                close_present,
    input  wire logic signed [fwma_pkg::SAMPLE_W-1:0] open_sample,
    input  wire logic                                open_present,
    input  wire logic                                series_end,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic signed      [fwma_pkg::SAMPLE_W-1:0] close_average,
    output logic signed      [fwma_pkg::SAMPLE_W-1:0] open_average,
    output logic                                     final_result
);

    import fwma_pkg::*;

    localparam int SUM_W  = SAMPLE_W + $clog2(WINDOW_LENGTH);
    localparam int CNT_W  = $clog2(WINDOW_LENGTH + 1);
    localparam int IDX_W  = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
    localparam int DATA_W = 2 * SAMPLE_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_START,
        S_DIV,
        S_EMIT
    } state_t;

    state_t                    state_reg;
    logic [CNT_W-1:0]          fill_reg;
    logic [IDX_W-1:0]          slot_reg;
    logic signed [SUM_W-1:0]   close_sum_reg;
    logic signed [SUM_W-1:0]   open_sum_reg;
    logic                      end_reg;
    logic                      out_valid_reg;
    logic signed [SAMPLE_W-1:0] close_average_reg;
    logic signed [SAMPLE_W-1:0] open_average_reg;
    logic                      final_result_reg;

    logic                      in_fire;
    logic                      emit_fire;
    logic                      emit_final;
    logic signed [SAMPLE_W-1:0] close_in;
    logic signed [SAMPLE_W-1:0] open_in;
    logic [CNT_W-1:0]          fill_inc;
    logic [IDX_W-1:0]          slot_inc;
    logic [CNT_W:0]            slot_wide;
    logic [CNT_W:0]            fill_wide;
    logic [CNT_W:0]            oldest_wide;
    logic [IDX_W-1:0]          oldest_idx;
    logic [DATA_W-1:0]         rd_data;
    logic signed [SAMPLE_W-1:0] close_old;
    logic signed [SAMPLE_W-1:0] open_old;
    logic signed [SUM_W-1:0]   quot_close;
    logic signed [SUM_W-1:0]   quot_open;
    div_status_t               div_status;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign emit_fire = (state_reg == S_EMIT) && (!out_valid_reg || out_ready);
    assign emit_final = end_reg && (fill_reg == CNT_W'(1));

    assign close_in = close_present ? close_sample : '0;
    assign open_in  = open_present ? open_sample : '0;
    assign fill_inc = fill_reg + 1'b1;
    assign slot_inc = (slot_reg == IDX_W'(WINDOW_LENGTH - 1)) ? '0 : slot_reg + 1'b1;

    assign slot_wide   = (CNT_W + 1)'(slot_reg);
    assign fill_wide   = (CNT_W + 1)'(fill_reg);
    assign oldest_wide = (slot_wide >= fill_wide) ? slot_wide - fill_wide
                       : slot_wide + (CNT_W + 1)'(WINDOW_LENGTH) - fill_wide;
    assign oldest_idx  = oldest_wide[IDX_W-1:0];

    assign close_old = rd_data[DATA_W-1:SAMPLE_W];
    assign open_old  = rd_data[SAMPLE_W-1:0];

    fwma_hist_mem #(
        .DEPTH  (WINDOW_LENGTH),
        .DATA_W (DATA_W),
        .ADDR_W (IDX_W)
    ) u_hist_mem (
        .clk     (clk),
        .wr_en   (in_fire),
        .wr_addr (slot_reg),
        .wr_data ({close_in, open_in}),
        .rd_en   (state_reg == S_START),
        .rd_addr (oldest_idx),
        .rd_data (rd_data)
    );

    fwma_divider #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_divider (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (state_reg == S_START),
        .dividend_close (close_sum_reg),
        .dividend_open  (open_sum_reg),
        .divisor        (fill_reg),
        .quotient_close (quot_close),
        .quotient_open  (quot_open),
        .status         (div_status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            slot_reg      <= '0;
            close_sum_reg <= '0;
            open_sum_reg  <= '0;
            end_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready && !emit_fire)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        fill_reg      <= fill_inc;
                        slot_reg      <= slot_inc;
                        close_sum_reg <= close_sum_reg + SUM_W'(close_in);
                        open_sum_reg  <= open_sum_reg + SUM_W'(open_in);
                        end_reg       <= series_end;
                        if (series_end || (fill_inc == CNT_W'(WINDOW_LENGTH)))
                        begin
                            state_reg <= S_START;
                        end
                    end
                end
                S_START:
                begin
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (div_status.done && !div_status.busy)
                    begin
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    if (emit_fire)
                    begin
                        out_valid_reg <= 1'b1;
                        fill_reg      <= fill_reg - 1'b1;
                        if (end_reg && !emit_final)
                        begin
                            close_sum_reg <= close_sum_reg - SUM_W'(close_old);
                            open_sum_reg  <= open_sum_reg - SUM_W'(open_old);
                            state_reg     <= S_START;
                        end
                        else
                        begin
                            state_reg <= S_IDLE;
                            if (end_reg)
                            begin
                                slot_reg      <= '0;
                                close_sum_reg <= '0;
                                open_sum_reg  <= '0;
                            end
                            else
                            begin
                                close_sum_reg <= close_sum_reg - SUM_W'(close_old);
                                open_sum_reg  <= open_sum_reg - SUM_W'(open_old);
                            end
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_fire)
        begin
            close_average_reg <= quot_close[SAMPLE_W-1:0];
            open_average_reg  <= quot_open[SAMPLE_W-1:0];
            final_result_reg  <= emit_final;
        end
    end

    assign out_valid     = out_valid_reg;
    assign close_average = close_average_reg;
    assign open_average  = open_average_reg;
    assign final_result  = final_result_reg;

    // no new row while the divider still works on a window
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !div_status.busy)
        else $error("row accepted while divider busy");

    // history never holds more rows than the window
    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(WINDOW_LENGTH))
        else $error("history overfilled");

    // the final result of a series leaves the history empty and the ring restarted
    assert property (@(posedge clk) disable iff (!rst_n)
        (emit_fire && emit_final) |=> (fill_reg == '0) && (slot_reg == '0))
        else $error("history not empty after final result");

    // a row that neither fills the window nor ends the series yields no result
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && !series_end && (fill_inc != CNT_W'(WINDOW_LENGTH)))
        |=> (state_reg == S_IDLE))
        else $error("unexpected result sequence");

    // the emit step only runs after the divider has finished
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> (div_status.done && !div_status.busy))
        else $error("emit without finished quotient");

endmodule

`default_nettype wire

>>> dv/tb_top.sv
// testbench for forward_window_moving_average_unit: directed rows, then random series
// checks every window mean against a predictor of the five-row forward window or a typed value
// depends on fwma_pkg and forward_window_moving_average_unit
`timescale 1ns / 1ps

module tb_top;

    localparam int WIN = fwma_pkg::WINDOW_LENGTH_DEF;

    typedef logic signed [fwma_pkg::SAMPLE_W-1:0] sample_t;

    localparam sample_t Q_ONE = 48'sd65536;
    localparam sample_t SAMPLE_MAX = {1'b0, {47{1'b1}}};
    localparam sample_t SAMPLE_MIN = {1'b1, 47'b0};

    typedef struct {
        sample_t close_sample;
        bit      close_present;
        sample_t open_sample;
        bit      open_present;
        bit      series_end;
        bit      typed;
        sample_t typed_close;
        sample_t typed_open;
    } row_t;

    typedef struct {
        sample_t close_average;
        sample_t open_average;
        bit      final_result;
    } mean_t;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    in_valid = 1'b0;
    logic    in_ready;
    sample_t close_sample = '0;
    logic    close_present = 1'b0;
    sample_t open_sample = '0;
    logic    open_present = 1'b0;
    logic    series_end = 1'b0;
    logic    out_valid;
    logic    out_ready = 1'b0;
    sample_t close_average;
    sample_t open_average;
    logic    final_result;

    longint  close_rows[$];
    longint  open_rows[$];
    longint  close_sum = 0;
    longint  open_sum = 0;
    mean_t   row_means[$];
    mean_t   pending_means[$];
    int      error_count = 0;
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;
    int      stall_requests = 0;
    row_t    directed_rows [21];

    forward_window_moving_average_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .close_sample  (close_sample),
        .close_present (close_present),
        .open_sample   (open_sample),
        .open_present  (open_present),
        .series_end    (series_end),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .close_average (close_average),
        .open_average  (open_average),
        .final_result  (final_result)
    );

    always #1 clk = ~clk;

    // mean of the oldest held row's window, then drop that row
    task automatic emit_oldest_mean(input bit last);
        mean_t  m;
        longint cnt;
        longint ca;
        longint oa;
        cnt = close_rows.size();
        ca = close_sum / cnt;
        oa = open_sum / cnt;
        m.close_average = ca[fwma_pkg::SAMPLE_W-1:0];
        m.open_average = oa[fwma_pkg::SAMPLE_W-1:0];
        m.final_result = last;
        row_means = {row_means, m};
        close_sum -= close_rows.pop_front();
        open_sum -= open_rows.pop_front();
    endtask

    task automatic advance_window(input row_t r);
        longint c;
        longint o;
        c = r.close_present ? longint'(r.close_sample) : 0;
        o = r.open_present ? longint'(r.open_sample) : 0;
        row_means.delete();
        if (close_rows.size() >= WIN)
            emit_oldest_mean(1'b0);
        close_rows = {close_rows, c};
        open_rows = {open_rows, o};
        close_sum += c;
        open_sum += o;
        if (close_rows.size() >= WIN)
            emit_oldest_mean(r.series_end && close_rows.size() == 1);
        if (r.series_end)
        begin
            while (close_rows.size() > 0)
                emit_oldest_mean(close_rows.size() == 1);
            close_sum = 0;
            open_sum = 0;
        end
    endtask

    task automatic send_row(input row_t r);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        close_sample <= r.close_sample;
        close_present <= r.close_present;
        open_sample <= r.open_sample;
        open_present <= r.open_present;
        series_end <= r.series_end;
        do @(posedge clk); while (!in_ready);
        advance_window(r);
        foreach (row_means[k])
        begin
            if (r.typed)
            begin
                row_means[k].close_average = r.typed_close;
                row_means[k].open_average = r.typed_open;
            end
            pending_means = {pending_means, row_means[k]};
        end
    endtask

    task automatic drain_means();
        in_valid <= 1'b0;
        while (pending_means.size() != 0)
            @(posedge clk);
    endtask

    function automatic sample_t random_sample();
        logic [63:0] raw;
        int          v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4:
            begin
                raw = {$urandom, $urandom};
                return raw[fwma_pkg::SAMPLE_W-1:0];
            end
            5, 6, 7:
            begin
                v = $urandom_range(0, 2000000) - 1000000;
                return sample_t'(v);
            end
            8: return SAMPLE_MAX;
            default: return SAMPLE_MIN;
        endcase
    endfunction

    function automatic row_t random_row(input bit last_row);
        row_t r;
        r.close_sample = random_sample();
        r.close_present = ($urandom_range(0, 7) != 0);
        r.open_sample = random_sample();
        r.open_present = ($urandom_range(0, 7) != 0);
        r.series_end = last_row;
        r.typed = 1'b0;
        r.typed_close = '0;
        r.typed_open = '0;
        return r;
    endfunction

    task automatic run_series(input int s_idle, input int r_idle, input int rows_wanted,
                              input bit with_stall);
        int sent;
        int len;
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        if (with_stall)
            stall_requests++;
        sent = 0;
        while (sent < rows_wanted)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 24) : $urandom_range(1, 12);
            for (int i = 0; i < len; i++)
            begin
                send_row(random_row(i == len - 1));
                sent++;
            end
        end
        drain_means();
    endtask

    // receiver: random back-pressure, plus long holds on request
    initial
    begin
        int stalls_served;
        int hold_left;
        stalls_served = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (stalls_served < stall_requests)
            begin
                stalls_served++;
                hold_left = 400;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        mean_t m;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_means.size() == 0)
            begin
                $error("unexpected transaction: close_average %0d open_average %0d",
                       close_average, open_average);
                error_count++;
            end
            else
            begin
                m = pending_means.pop_front();
                if (close_average !== m.close_average)
                begin
                    $error("close_average: expected %0d, got %0d", m.close_average,
                           close_average);
                    error_count++;
                end
                if (open_average !== m.open_average)
                begin
                    $error("open_average: expected %0d, got %0d", m.open_average,
                           open_average);
                    error_count++;
                end
                if (final_result !== m.final_result)
                begin
                    $error("final_result: expected %0d, got %0d", m.final_result,
                           final_result);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        #1000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        directed_rows = '{
            // single-row series, the first with open missing
            '{5 * Q_ONE, 1, 48'sd123, 0, 1, 1, 5 * Q_ONE, '0},
            '{-48'sd1, 1, 48'sd1, 1, 1, 1, -48'sd1, 48'sd1},
            '{SAMPLE_MIN, 1, SAMPLE_MAX, 1, 1, 1, SAMPLE_MIN, SAMPLE_MAX},
            // full window of extremes, then end with a full window pending
            '{SAMPLE_MAX, 1, SAMPLE_MIN, 1, 0, 0, '0, '0},
            '{SAMPLE_MAX, 1, SAMPLE_MIN, 1, 0, 0, '0, '0},
            '{SAMPLE_MAX, 1, SAMPLE_MIN, 1, 0, 0, '0, '0},
            '{SAMPLE_MAX, 1, SAMPLE_MIN, 1, 0, 0, '0, '0},
            '{SAMPLE_MAX, 1, SAMPLE_MIN, 1, 0, 1, SAMPLE_MAX, SAMPLE_MIN},
            '{SAMPLE_MAX, 1, SAMPLE_MIN, 1, 1, 1, SAMPLE_MAX, SAMPLE_MIN},
            // truncation toward zero on short tails
            '{48'sd1, 1, -48'sd1, 1, 0, 0, '0, '0},
            '{48'sd0, 1, 48'sd0, 1, 0, 0, '0, '0},
            '{48'sd0, 1, 48'sd0, 1, 1, 0, '0, '0},
            '{48'sd7, 1, -48'sd7, 1, 0, 0, '0, '0},
            '{SAMPLE_MAX, 0, SAMPLE_MIN, 0, 1, 0, '0, '0},
            // end lands on the fifth row, then a two-row series of maxima
            '{10 * Q_ONE, 1, -48'sd1, 1, 0, 0, '0, '0},
            '{20 * Q_ONE, 1, -48'sd2, 1, 0, 0, '0, '0},
            '{30 * Q_ONE, 1, -48'sd3, 0, 0, 0, '0, '0},
            '{40 * Q_ONE, 0, -48'sd4, 1, 0, 0, '0, '0},
            '{50 * Q_ONE, 1, -48'sd5, 1, 1, 0, '0, '0},
            '{SAMPLE_MAX, 1, SAMPLE_MAX, 1, 0, 0, '0, '0},
            '{SAMPLE_MAX, 1, SAMPLE_MAX, 1, 1, 1, SAMPLE_MAX, SAMPLE_MAX}
        };
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_idle_pct = 14;
        recv_idle_pct = 69;
        foreach (directed_rows[i])
            send_row(directed_rows[i]);
        drain_means();
        run_series(14, 69, 100, 1'b0);
        run_series(69, 14, 100, 1'b0);
        run_series(0, 0, 100, 1'b1);
        repeat (120) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/fwma_pkg.sv
hw/rtl/fwma_hist_mem.sv
hw/rtl/fwma_divider.sv
hw/rtl/forward_window_moving_average_unit.sv
dv/tb_top.sv
